>>> rtl/scf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and encoders of the superstrip code formatter.
// ---------------------------------------------------------------------------
package scf_pkg;

   localparam int STRIP_W          = 10;
   localparam int SS_SIZE_W        = 11;
   localparam logic [SS_SIZE_W-1:0] SS_SIZE_RESET = 11'd32;
   localparam logic [SS_SIZE_W-1:0] SS_SIZE_MIN   = 11'd1;

   // divider: one quotient bit per step, a few steps per stage
   localparam int STEPS_PER_STAGE  = 2;
   localparam int NUM_DIV_STAGES   = STRIP_W / STEPS_PER_STAGE;

   localparam logic [4:0] BARREL_LAYER_LIMIT = 5'd11;
   localparam logic [4:0] COARSE_LAYER_LO    = 5'd5;
   localparam logic [4:0] COARSE_LAYER_HI    = 5'd7;
   localparam logic [3:0] FAKE_PHI           = 4'd15;

   // don't-care value codes
   localparam logic [2:0] DC_FIXED0 = 3'd0;
   localparam logic [2:0] DC_FIXED1 = 3'd1;
   localparam logic [2:0] DC_ANY    = 3'd2;
   localparam logic [2:0] DC_NONE   = 3'd4;

   // don't-care counts
   localparam logic [1:0] DC_USED_ZERO  = 2'd0;
   localparam logic [1:0] DC_USED_ONE   = 2'd1;
   localparam logic [1:0] DC_USED_THREE = 2'd3;

   localparam logic [1:0] AM_DC_WIDTH_TWO   = 2'd2;
   localparam logic [1:0] AM_DC_WIDTH_THREE = 2'd3;

   typedef struct packed {
      logic [4:0]  layer_number;
      logic [6:0]  module_index;
      logic [3:0]  ladder_phi;
      logic [9:0]  strip_number;
      logic [4:0]  segment_number;
      logic        is_pixel_strip;
      logic        fake_hit;
      logic [1:0]  dc_count;
      logic [2:0]  dc_value_a;
      logic [2:0]  dc_value_b;
      logic [2:0]  dc_value_c;
      logic        tag_layer_flag;
   } req_type;

   typedef struct packed {
      logic [15:0] pattern_code;
      logic [17:0] am_word;
      logic [1:0]  am_dc_width;
      logic        module_overflow;
   } rsp_type;

   // request plus the running state of the restoring divider
   typedef struct packed {
      req_type              hit;
      logic [STRIP_W-1:0]   dvd;
      logic [STRIP_W-1:0]   rem;
      logic [STRIP_W-1:0]   quo;
   } div_work_type;

   function automatic logic [1:0] dc_encode(input logic [2:0] v);
      logic [1:0] enc;
      case (v)
         DC_ANY:    enc = 2'b00;
         DC_FIXED0: enc = 2'b01;
         DC_FIXED1: enc = 2'b10;
         DC_NONE:   enc = 2'b11;
         default:   enc = v[1:0];
      endcase
      return enc;
   endfunction

   function automatic logic [1:0] bit_encode(input logic b);
      return b ? 2'b10 : 2'b01;
   endfunction

endpackage
`default_nettype wire

>>> rtl/scf_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_div_step
// One register stage of the strip / superstrip-size restoring divider.
// ---------------------------------------------------------------------------
module scf_div_step (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          stage_en,
   input  wire logic                          up_vld,
   input  wire scf_pkg::div_work_type         up_work,
   input  wire logic [scf_pkg::SS_SIZE_W-1:0] divisor,
   output logic                               stage_vld,
   output scf_pkg::div_work_type              stage_work
);
   import scf_pkg::*;

   logic           vld_ff;
   div_work_type   work_ff;
   div_work_type   work_in;
   logic [STRIP_W:0] trial [STEPS_PER_STAGE];
   logic [STRIP_W:0] diff  [STEPS_PER_STAGE];

   always_comb begin
      work_in = up_work;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         // shift next dividend bit into the partial remainder
         trial[k] = {work_in.rem, work_in.dvd[STRIP_W-1]};
         diff[k]  = trial[k] - divisor;
         work_in.dvd = {work_in.dvd[STRIP_W-2:0], 1'b0};
         if (trial[k] >= divisor) begin
            work_in.rem = diff[k][STRIP_W-1:0];
            work_in.quo = {work_in.quo[STRIP_W-2:0], 1'b1};
         end else begin
            work_in.rem = trial[k][STRIP_W-1:0];
            work_in.quo = {work_in.quo[STRIP_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (stage_en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         work_ff <= work_in;
      end
   end

   assign stage_vld  = vld_ff;
   assign stage_work = work_ff;

endmodule
`default_nettype wire

>>> rtl/scf_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scf_pack
// Coarse z, Gray code, pattern code and memory word; output register.
// ---------------------------------------------------------------------------
module scf_pack (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  stage_en,
   input  wire logic                  up_vld,
   input  wire scf_pkg::div_work_type up_work,
   output logic                       rsp_valid,
   output scf_pkg::rsp_type           rsp_data
);
   import scf_pkg::*;

   logic       vld_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   req_type    hit;
   logic       seg;
   logic [7:0] zfull;
   logic [6:0] zb;
   logic [3:0] cmod;
   logic       cseg;
   logic [3:0] phi;
   logic [6:0] gray;
   logic [15:0] code;
   logic [2:0] dca, dcb, dcc;
   logic [1:0] d0, d1, d2;
   logic [4:0] s5;
   logic [17:0] am;

   always_comb begin
      hit = up_work.hit;
      seg = hit.is_pixel_strip ? hit.segment_number[4] : (|hit.segment_number);
      zfull = {hit.module_index, ~seg};
      if (hit.layer_number >= COARSE_LAYER_LO && hit.layer_number <= COARSE_LAYER_HI) begin
         zb = {1'b0, zfull[7:2]};
      end else begin
         zb = zfull[7:1];
      end

      if (hit.fake_hit) begin
         cmod = 4'd0;
         cseg = 1'b0;
         phi  = FAKE_PHI;
         gray = 7'd0;
      end else begin
         if (hit.layer_number < BARREL_LAYER_LIMIT) begin
            cmod = zb[4:1];
            cseg = zb[0];
         end else begin
            cmod = hit.module_index[3:0];
            cseg = hit.is_pixel_strip & seg;
         end
         phi  = hit.ladder_phi;
         gray = up_work.quo[6:0] ^ up_work.quo[7:1];
      end
      code = {cmod, cseg, phi, gray};

      // fake ladder forces all don't-cares to fixed zero
      if (phi == FAKE_PHI) begin
         dca = DC_FIXED0;
         dcb = DC_FIXED0;
         dcc = DC_FIXED0;
      end else begin
         dca = hit.dc_value_a;
         dcb = hit.dc_value_b;
         dcc = hit.dc_value_c;
      end

      d2 = dc_encode(dcc);
      case (hit.dc_count)
         DC_USED_ZERO: begin
            d0 = bit_encode(gray[1]);
            d1 = bit_encode(gray[0]);
            s5 = gray[6:2];
         end
         DC_USED_ONE: begin
            d0 = bit_encode(gray[0]);
            d1 = dc_encode(dca);
            s5 = gray[5:1];
         end
         default: begin
            d0 = dc_encode(dca);
            d1 = dc_encode(dcb);
            s5 = gray[4:0];
         end
      endcase

      if (hit.dc_count == DC_USED_THREE) begin
         am = {cmod[2:0], cseg, phi, gray[3] | hit.tag_layer_flag, gray[2:0], d0, d1, d2};
      end else begin
         am = {cmod, cseg, phi, s5[4] | hit.tag_layer_flag, s5[3:0], d0, d1};
      end

      rsp_in.pattern_code    = code;
      rsp_in.am_word         = am;
      rsp_in.am_dc_width     = (hit.dc_count == DC_USED_THREE) ? AM_DC_WIDTH_THREE
                                                                : AM_DC_WIDTH_TWO;
      rsp_in.module_overflow = (hit.dc_count == DC_USED_THREE) & cmod[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (stage_en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/superstrip_code_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// superstrip_code_formatter
// Turns detector hits into 16-bit superstrip pattern codes and 18-bit
// associative-memory words.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one hit per request (req_valid / req_stall), rsp_* one
//   formatted result per request (rsp_valid / rsp_stall). csr_wr_en with
//   csr_wr_data sets the superstrip size; write it only while idle. A size of
//   zero acts as one.
//   Six register stages: five divider stages of two quotient bits each (the
//   strip / size division sets the depth), then the packing stage with the
//   output register.
//   Throughput is one request per cycle while the result is not stalled.
//   Each stage loads whenever it is empty or the stage after it moves, so
//   bubbles are squeezed out and a new request is taken while a finished
//   result waits, as long as some stage is free. req_stall rises only when
//   all six stages hold requests and the result is stalled.
//   Reset clears every stage valid bit and sets the superstrip size to 32;
//   req_stall is low after reset.
// ---------------------------------------------------------------------------
module superstrip_code_formatter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire scf_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output scf_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [scf_pkg::SS_SIZE_W-1:0] csr_wr_data
);
   import scf_pkg::*;

   logic [SS_SIZE_W-1:0] divisor_ff;
   logic                 stage_en  [NUM_DIV_STAGES+1];
   logic                 stage_vld [NUM_DIV_STAGES];
   div_work_type         stage_work[NUM_DIV_STAGES];
   logic                 vld_chain [NUM_DIV_STAGES+1];
   div_work_type         work_chain[NUM_DIV_STAGES+1];

   // zero size behaves as one
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= SS_SIZE_RESET;
      end else if (csr_wr_en) begin
         divisor_ff <= (csr_wr_data == '0) ? SS_SIZE_MIN : csr_wr_data;
      end
   end

   always_comb begin
      stage_en[NUM_DIV_STAGES] = !rsp_valid || !rsp_stall;
      for (int i = NUM_DIV_STAGES - 1; i >= 0; i--) begin
         stage_en[i] = !stage_vld[i] || stage_en[i+1];
      end
   end

   assign req_stall = !stage_en[0];

   always_comb begin
      vld_chain[0]            = req_valid;
      work_chain[0].hit       = req_data;
      work_chain[0].dvd       = req_data.strip_number;
      work_chain[0].rem       = '0;
      work_chain[0].quo       = '0;
      for (int i = 0; i < NUM_DIV_STAGES; i++) begin
         vld_chain[i+1]  = stage_vld[i];
         work_chain[i+1] = stage_work[i];
      end
   end

   for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
      scf_div_step u_step (
         .clock      (clock),
         .reset      (reset),
         .stage_en   (stage_en[g]),
         .up_vld     (vld_chain[g]),
         .up_work    (work_chain[g]),
         .divisor    (divisor_ff),
         .stage_vld  (stage_vld[g]),
         .stage_work (stage_work[g])
      );
   end

   scf_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (stage_en[NUM_DIV_STAGES]),
      .up_vld    (vld_chain[NUM_DIV_STAGES]),
      .up_work   (work_chain[NUM_DIV_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && stage_vld[0]
                     && stage_vld[NUM_DIV_STAGES-1]))
      else $error("request stalled while pipeline has room");

   a_overflow_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.module_overflow) |-> rsp_data.am_dc_width == AM_DC_WIDTH_THREE)
      else $error("module overflow without three don't-care fields");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      divisor_ff != '0)
      else $error("superstrip divisor is zero");

endmodule
`default_nettype wire

>>> dv/superstrip_code_formatter_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// superstrip_code_formatter_test
// Self-checking bench for the superstrip code formatter: a queue-fed driver
// sends hits with random gaps, a monitor stalls at random and checks every
// formatted word against a behavioral predictor, over several superstrip
// sizes including zero and the field extremes.
// ---------------------------------------------------------------------------
module superstrip_code_formatter_test;
   import scf_pkg::*;

   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_GAP       = 12;
   localparam int NUM_PHASES    = 8;
   localparam int HITS_PER_PHASE = 113;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [SS_SIZE_W-1:0] csr_wr_data = '0;

   req_type              hit_queue[$];
   rsp_type              expected_codes[$];
   logic [SS_SIZE_W-1:0] ss_size = SS_SIZE_RESET;
   bit                   send_gaps = 1'b0;
   bit                   recv_gaps = 1'b0;
   int                   gap_left = 0;
   int                   stall_left = 0;
   int                   error_count = 0;

   superstrip_code_formatter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // two-bit don't-care field of the memory word
   function automatic logic [1:0] dc_field(input logic [2:0] v);
      case (v)
         DC_ANY:    return 2'b00;
         DC_FIXED0: return 2'b01;
         DC_FIXED1: return 2'b10;
         DC_NONE:   return 2'b11;
         default:   return v[1:0];
      endcase
   endfunction

   function automatic logic [1:0] code_bit(input logic b);
      return b ? 2'b10 : 2'b01;
   endfunction

   function automatic rsp_type format_hit(input req_type h, input logic [SS_SIZE_W-1:0] size);
      int unsigned divisor, ss, seg, z, cmod, cseg;
      logic [3:0]  phi, zc, lad;
      logic [15:0] code;
      logic        sg;
      logic [6:0]  s;
      logic [2:0]  va, vb, vc;
      logic [1:0]  d0, d1, d2;
      logic [17:0] am;
      rsp_type     r;
      phi = h.ladder_phi;
      if (h.fake_hit) begin
         cmod = 0;
         cseg = 0;
         phi = FAKE_PHI;
         ss = 0;
      end else begin
         divisor = (size == 0) ? 1 : size;
         ss = h.strip_number / divisor;
         if (h.is_pixel_strip)
            seg = h.segment_number / 16;
         else
            seg = (h.segment_number > 1) ? 1 : h.segment_number;
         if (h.layer_number < BARREL_LAYER_LIMIT) begin
            // coarse z from module and segment
            z = h.module_index * 2 + 1 - seg;
            if (h.layer_number >= COARSE_LAYER_LO && h.layer_number <= COARSE_LAYER_HI)
               z = z / 4;
            else
               z = z / 2;
            cmod = z / 2;
            cseg = z % 2;
         end else begin
            if (!h.is_pixel_strip)
               seg = 0;
            cmod = h.module_index;
            cseg = seg;
         end
      end
      ss = (ss ^ (ss >> 1)) & 32'h7F;
      code = {cmod[3:0], cseg[0], phi, ss[6:0]};

      zc  = code[15:12];
      sg  = code[11];
      lad = code[10:7];
      s   = code[6:0];
      va  = h.dc_value_a;
      vb  = h.dc_value_b;
      vc  = h.dc_value_c;
      if (lad == FAKE_PHI) begin
         va = DC_FIXED0;
         vb = DC_FIXED0;
         vc = DC_FIXED0;
      end
      case (h.dc_count)
         DC_USED_ZERO: begin
            d0 = code_bit(s[1]);
            d1 = code_bit(s[0]);
            s = s >> 2;
         end
         DC_USED_ONE: begin
            d0 = code_bit(s[0]);
            d1 = dc_field(va);
            s = s >> 1;
         end
         default: begin
            d0 = dc_field(va);
            d1 = dc_field(vb);
         end
      endcase
      if (h.dc_count != DC_USED_THREE) begin
         am = {zc, sg, lad, s[4:0], d0, d1};
         if (h.tag_layer_flag)
            am[8] = 1'b1;
         r.am_dc_width = AM_DC_WIDTH_TWO;
         r.module_overflow = 1'b0;
      end else begin
         d2 = dc_field(vc);
         am = {zc[2:0], sg, lad, s[3:0], d0, d1, d2};
         if (h.tag_layer_flag)
            am[9] = 1'b1;
         r.am_dc_width = AM_DC_WIDTH_THREE;
         r.module_overflow = (zc > 4'd7);
      end
      r.pattern_code = code;
      r.am_word = am;
      return r;
   endfunction

   function automatic req_type random_hit();
      req_type h;
      h.layer_number   = 5'($urandom_range(0, 31));
      h.module_index   = 7'($urandom_range(0, 127));
      h.ladder_phi     = ($urandom_range(0, 5) == 0) ? FAKE_PHI : 4'($urandom_range(0, 15));
      h.strip_number   = 10'($urandom_range(0, 1023));
      h.segment_number = 5'($urandom_range(0, 31));
      h.is_pixel_strip = 1'($urandom_range(0, 1));
      h.fake_hit       = ($urandom_range(0, 7) == 0);
      h.dc_count       = 2'($urandom_range(0, 3));
      h.dc_value_a     = 3'($urandom_range(0, 7));
      h.dc_value_b     = 3'($urandom_range(0, 7));
      h.dc_value_c     = 3'($urandom_range(0, 7));
      h.tag_layer_flag = 1'($urandom_range(0, 1));
      return h;
   endfunction

   task automatic report_error(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_hit(input req_type item);
      hit_queue.insert(hit_queue.size(), item);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_codes.insert(expected_codes.size(), format_hit(req_data, ss_size));
         if (gap_left > 0 || hit_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_data <= hit_queue.pop_front();
            req_valid <= 1'b1;
            gap_left = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               report_error("unexpected response", 32'(rsp_data.pattern_code), 32'd0);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_data.pattern_code !== want.pattern_code)
                  report_error("pattern_code", 32'(rsp_data.pattern_code),
                               32'(want.pattern_code));
               if (rsp_data.am_word !== want.am_word)
                  report_error("am_word", 32'(rsp_data.am_word), 32'(want.am_word));
               if (rsp_data.am_dc_width !== want.am_dc_width)
                  report_error("am_dc_width", 32'(rsp_data.am_dc_width),
                               32'(want.am_dc_width));
               if (rsp_data.module_overflow !== want.module_overflow)
                  report_error("module_overflow", 32'(rsp_data.module_overflow),
                               32'(want.module_overflow));
            end
            stall_left = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // sampled on the falling edge so driver updates have settled
   task automatic wait_drained();
      while (hit_queue.size() != 0 || req_valid || expected_codes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ss_size(input logic [SS_SIZE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ss_size = value;
   endtask

   initial begin
      req_type              h;
      logic [SS_SIZE_W-1:0] size;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed hits at the reset superstrip size
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      h = '0;
      queue_hit(h);
      h = '1;
      h.fake_hit = 1'b0;
      queue_hit(h);
      h = random_hit();
      h.fake_hit = 1'b1;
      queue_hit(h);
      // barrel coarse layers, plain barrel, segment clamp
      h = random_hit();
      h.fake_hit = 1'b0; h.ladder_phi = 4'd3; h.layer_number = 5'd5;
      h.module_index = 7'd9; h.segment_number = 5'd0; h.is_pixel_strip = 1'b0;
      h.dc_count = DC_USED_ZERO;
      queue_hit(h);
      h.layer_number = 5'd7; h.module_index = 7'd100; h.segment_number = 5'd1;
      h.dc_count = DC_USED_ONE;
      queue_hit(h);
      h.layer_number = 5'd6; h.is_pixel_strip = 1'b1; h.segment_number = 5'd20;
      queue_hit(h);
      h.layer_number = 5'd4; h.is_pixel_strip = 1'b0; h.module_index = 7'd127;
      h.segment_number = 5'd0; h.dc_count = 2'd2;
      queue_hit(h);
      h.layer_number = 5'd10; h.segment_number = 5'd9; h.dc_count = DC_USED_THREE;
      queue_hit(h);
      // endcap: segment forced to zero off pixel-strip
      h.layer_number = 5'd11; h.segment_number = 5'd3; h.module_index = 7'd5;
      queue_hit(h);
      h.layer_number = 5'd20; h.is_pixel_strip = 1'b1; h.segment_number = 5'd31;
      h.module_index = 7'd7;
      queue_hit(h);
      // module overflow with three don't-cares
      h.layer_number = 5'd31; h.module_index = 7'd8; h.tag_layer_flag = 1'b1;
      queue_hit(h);
      h.module_index = 7'd127;
      queue_hit(h);
      // every don't-care value in each field, with the count cycling through all four
      for (int v = 0; v < 8; v++) begin
         h = random_hit();
         h.fake_hit = 1'b0;
         h.ladder_phi = 4'(v);
         h.dc_value_a = 3'(v);
         h.dc_value_b = 3'(7 - v);
         h.dc_value_c = 3'((v + 3) % 8);
         h.dc_count = 2'(v % 4);
         h.tag_layer_flag = v[0];
         queue_hit(h);
      end
      // real hit on phi 15 reads like a fake one in the memory word
      h = random_hit();
      h.fake_hit = 1'b0; h.ladder_phi = FAKE_PHI; h.dc_count = 2'd2;
      h.dc_value_a = DC_FIXED1; h.dc_value_b = DC_NONE;
      queue_hit(h);
      h = random_hit();
      h.fake_hit = 1'b0; h.layer_number = 5'd0; h.strip_number = 10'd1023;
      h.dc_count = DC_USED_ZERO; h.tag_layer_flag = 1'b1;
      queue_hit(h);
      wait_drained();

      // random hits over a sweep of superstrip sizes
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: size = SS_SIZE_MIN;
            1: size = 11'd1024;
            2: size = 11'd0;
            3: size = 11'd2047;
            4: size = 11'd3;
            5: size = 11'd17;
            default: size = 11'($urandom_range(1, 1024));
         endcase
         write_ss_size(size);
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < HITS_PER_PHASE; i++)
            queue_hit(random_hit());
         wait_drained();
      end

      if (error_count == 0)
         $display("superstrip_code_formatter_test: clean");
      else
         $display("superstrip_code_formatter_test: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("superstrip_code_formatter_test: errors");
      $finish;
   end

endmodule

>>> files.f
rtl/scf_pkg.sv
rtl/scf_div_step.sv
rtl/scf_pack.sv
rtl/superstrip_code_formatter.sv
dv/superstrip_code_formatter_test.sv
